/* sv/qpht_pkg.sv */
// Package for the quadratic-probe hash table: operation and result codes,
// slot status, controller states and the command/status bundles.
// No dependencies.
`timescale 1ns / 1ps

package qpht_pkg;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_SEARCH = 2'd2;

	localparam logic [2:0] RC_INSERTED  = 3'd0;
	localparam logic [2:0] RC_FULL      = 3'd1;
	localparam logic [2:0] RC_DELETED   = 3'd2;
	localparam logic [2:0] RC_NOT_FOUND = 3'd3;
	localparam logic [2:0] RC_FOUND     = 3'd4;

	typedef enum logic [1:0] {
		ST_EMPTY    = 2'd0,
		ST_OCCUPIED = 2'd1,
		ST_DELETED  = 2'd2
	} slot_st_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HOME,
		S_ISSUE,
		S_PROBE
	} ctrl_state_t;

	typedef struct packed {
		logic clear;
		logic load;
		logic home_step;
		logic issue;
		logic advance;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic home_done;
		logic done;
	} dp_sts_t;

endpackage

/* sv/qpht_dp.sv */
// Datapath of the hash table: key and status memories, home slot unit,
// quadratic probe stepping, probe decision and the result register.
// Depends on qpht_pkg.
`timescale 1ns / 1ps

module qpht_dp import qpht_pkg::*; #(
	parameter int NUM_SLOTS = 16,
	parameter int KEY_BITS  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_sts_t     sts,
	input  logic [1:0]  operation,
	input  logic [31:0] key,
	output logic [2:0]  result_code,
	output logic [3:0]  slot
);

	localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;
	localparam int IW = $clog2(NUM_SLOTS);
	localparam int SW = (IW > 4) ? IW : 4;
	localparam bit POW2 = ((1 << IW) == NUM_SLOTS);

	logic [1:0]    op_q;
	logic [KW-1:0] key_q;
	logic [31:0]   key_ext;

	slot_st_t      status_mem [NUM_SLOTS];
	logic [KW-1:0] key_mem    [NUM_SLOTS];
	slot_st_t      rd_status_q;
	logic [KW-1:0] rd_key_q;
	logic [IW-1:0] rd_addr;

	logic [IW-1:0] clr_idx_q;
	logic [IW-1:0] home_val;

	logic [IW-1:0] p_q;
	logic [IW-1:0] d_q;
	logic [IW-1:0] i_q;
	logic [IW:0]   p_sum;
	logic [IW:0]   d_sum;
	logic [IW-1:0] p_next;
	logic [IW-1:0] d_next;
	logic          last_probe;

	logic          dec_done;
	logic [2:0]    dec_code;
	logic          dec_use_slot;
	logic          dec_wr_status;
	slot_st_t      dec_status;
	logic          dec_wr_key;
	logic          key_hit;

	logic          st_we;
	logic [IW-1:0] st_waddr;
	slot_st_t      st_wdata;

	logic [2:0]    code_q;
	logic [SW-1:0] slot_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= operation;
			key_q <= key[KW-1:0];
		end
	end

	assign key_ext = 32'(key_q);

	// Clearing pass after reset walks the status memory once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
		end else if (cmd.clear) begin
			clr_idx_q <= clr_idx_q + 1'b1;
		end
	end

	assign sts.clr_last = (clr_idx_q == IW'(NUM_SLOTS - 1));

	generate
		if (POW2) begin : g_home_mask
			assign home_val      = key_ext[IW-1:0];
			assign sts.home_done = 1'b1;
		end else begin : g_home_fold
			// The key is first folded to 26 bits with 2^16 mod size, then reduced
			// with a reciprocal estimate of the quotient and one correcting subtract.
			localparam int          C16 = (1 << 16) % NUM_SLOTS;
			localparam logic [25:0] MU  = 26'((1 << 26) / NUM_SLOTS);
			logic [25:0] fold_prod;
			logic [51:0] quo_prod;
			logic [25:0] back_prod;
			logic [25:0] fold_q;
			logic [25:0] quo_q;
			logic [IW:0] rem_q;
			logic [1:0]  cnt_q;

			assign fold_prod = 26'(key_ext[31:16]) * 26'(C16);
			assign quo_prod  = {26'd0, fold_q} * {26'd0, MU};
			assign back_prod = quo_q * 26'(NUM_SLOTS);

			always_ff @(posedge clk) begin
				if (cmd.load) begin
					cnt_q <= 2'd2;
				end else if (cmd.home_step) begin
					cnt_q  <= cnt_q - 1'b1;
					fold_q <= fold_prod + 26'(key_ext[15:0]);
					quo_q  <= quo_prod[51:26];
					rem_q  <= (IW + 1)'(fold_q - back_prod);
				end
			end

			assign home_val = (rem_q >= (IW + 1)'(NUM_SLOTS)) ?
				IW'(rem_q - (IW + 1)'(NUM_SLOTS)) : rem_q[IW-1:0];
			assign sts.home_done = (cnt_q == '0);
		end
	endgenerate

	// Successive squares differ by 2i+1, so both the slot and the step advance
	// with one add and one conditional subtract each.
	assign p_sum  = {1'b0, p_q} + {1'b0, d_q};
	assign d_sum  = {1'b0, d_q} + (IW + 1)'(2);
	assign p_next = (p_sum >= (IW + 1)'(NUM_SLOTS)) ?
		IW'(p_sum - (IW + 1)'(NUM_SLOTS)) : p_sum[IW-1:0];
	assign d_next = (d_sum >= (IW + 1)'(NUM_SLOTS)) ?
		IW'(d_sum - (IW + 1)'(NUM_SLOTS)) : d_sum[IW-1:0];
	assign last_probe = (i_q == IW'(NUM_SLOTS - 1));

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			p_q <= home_val;
			d_q <= IW'(1);
			i_q <= '0;
		end else if (cmd.advance) begin
			p_q <= p_next;
			d_q <= d_next;
			i_q <= i_q + 1'b1;
		end
	end

	always_comb begin
		if (cmd.issue) begin
			rd_addr = home_val;
		end else if (cmd.advance) begin
			rd_addr = p_next;
		end else begin
			rd_addr = p_q;
		end
	end

	assign key_hit = (rd_status_q == ST_OCCUPIED) && (rd_key_q == key_q);

	always_comb begin
		dec_done      = 1'b0;
		dec_code      = RC_NOT_FOUND;
		dec_use_slot  = 1'b0;
		dec_wr_status = 1'b0;
		dec_status    = ST_OCCUPIED;
		dec_wr_key    = 1'b0;
		unique case (op_q)
			OP_INSERT: begin
				priority if (rd_status_q != ST_OCCUPIED) begin
					dec_done      = 1'b1;
					dec_code      = RC_INSERTED;
					dec_use_slot  = 1'b1;
					dec_wr_status = 1'b1;
					dec_wr_key    = 1'b1;
				end else if (last_probe) begin
					dec_done = 1'b1;
					dec_code = RC_FULL;
				end
			end
			OP_DELETE, OP_SEARCH: begin
				priority if (rd_status_q == ST_EMPTY) begin
					dec_done = 1'b1;
				end else if (key_hit) begin
					dec_done     = 1'b1;
					dec_use_slot = 1'b1;
					if (op_q == OP_DELETE) begin
						dec_code      = RC_DELETED;
						dec_wr_status = 1'b1;
						dec_status    = ST_DELETED;
					end else begin
						dec_code = RC_FOUND;
					end
				end else if (last_probe) begin
					dec_done = 1'b1;
				end
			end
			default: begin
				dec_done = 1'b1;
			end
		endcase
	end

	assign sts.done = dec_done;

	assign st_we    = cmd.clear || (cmd.commit && dec_wr_status);
	assign st_waddr = cmd.clear ? clr_idx_q : p_q;
	assign st_wdata = cmd.clear ? ST_EMPTY : dec_status;

	always_ff @(posedge clk) begin
		if (st_we) begin
			status_mem[st_waddr] <= st_wdata;
		end
		rd_status_q <= status_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && dec_wr_key) begin
			key_mem[p_q] <= key_q;
		end
		rd_key_q <= key_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			code_q <= dec_code;
			slot_q <= dec_use_slot ? SW'(p_q) : '0;
		end
	end

	assign result_code = code_q;
	assign slot        = slot_q[3:0];

endmodule

/* sv/qpht_ctrl.sv */
// Controller of the hash table: sequences clearing, home slot, probing and
// result hand-off, and owns both channel handshakes.
// Depends on qpht_pkg.
`timescale 1ns / 1ps

module qpht_ctrl import qpht_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	output logic    req_stall,
	output logic    rsp_valid,
	input  logic    rsp_stall,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_nxt;
	logic        rsp_valid_q;
	logic        out_free;

	// The result register may be refilled in the cycle its word is taken.
	assign out_free = !rsp_valid_q || !rsp_stall;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_CLEAR: if (sts.clr_last) state_nxt = S_IDLE;
			S_IDLE:  if (req_valid) state_nxt = S_HOME;
			S_HOME:  if (sts.home_done) state_nxt = S_ISSUE;
			S_ISSUE: state_nxt = S_PROBE;
			S_PROBE: if (sts.done && out_free) state_nxt = S_IDLE;
			default: state_nxt = S_CLEAR;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			S_CLEAR: cmd.clear = 1'b1;
			S_IDLE: begin
				req_stall = 1'b0;
				cmd.load  = req_valid;
			end
			S_HOME:  cmd.home_step = 1'b1;
			S_ISSUE: cmd.issue = 1'b1;
			S_PROBE: begin
				cmd.commit  = sts.done && out_free;
				cmd.advance = !sts.done;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nxt;
			rsp_valid_q <= cmd.commit || (rsp_valid_q && rsp_stall);
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

/* sv/quadratic_probe_hash_table.sv */
// Open-addressing hash table with quadratic probing. After reset the block
// runs a clearing pass over every slot with req_stall high. An item is then
// accepted, its home slot is computed (at once when NUM_SLOTS is a power of
// two, otherwise by registered fold, quotient estimate and remainder steps
// and a correcting subtract), the first read is issued and between 1 and
// NUM_SLOTS probes follow; the status and key memories, read once per
// cycle, set the probe rate, and the final probe holds while the result
// register is full. A finished word sits in the result register and the
// next request is taken while it waits; that request's result is held
// back until the waiting word is taken.
`timescale 1ns / 1ps

module quadratic_probe_hash_table import qpht_pkg::*; #(
	parameter int NUM_SLOTS = 16,
	parameter int KEY_BITS  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  operation,
	input  logic [31:0] key,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [2:0]  result_code,
	output logic [3:0]  slot
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	qpht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	qpht_dp #(
		.NUM_SLOTS (NUM_SLOTS),
		.KEY_BITS  (KEY_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.operation   (operation),
		.key         (key),
		.result_code (result_code),
		.slot        (slot)
	);

endmodule

/* sv/qpht_checker.sv */
// Port-level checks for the hash table, bound to the top level.
// Depends on qpht_pkg.
`timescale 1ns / 1ps

module qpht_checker import qpht_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_stall,
	input logic [1:0]  operation,
	input logic [31:0] key,
	input logic        rsp_valid,
	input logic        rsp_stall,
	input logic [2:0]  result_code,
	input logic [3:0]  slot
);

	// A stalled request word holds.
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_stall |=> req_valid && $stable(operation) && $stable(key))
		else $error("request word changed while stalled");

	// A stalled result word holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(result_code) && $stable(slot))
		else $error("result word changed while stalled");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (result_code == RC_INSERTED || result_code == RC_FULL ||
			result_code == RC_DELETED || result_code == RC_NOT_FOUND ||
			result_code == RC_FOUND))
		else $error("undefined result code");

	// Failed operations report slot zero.
	a_miss_slot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (result_code == RC_FULL || result_code == RC_NOT_FOUND)
		|-> slot == 4'd0)
		else $error("nonzero slot on a miss");

	// The block works on one request at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while busy");

endmodule

bind quadratic_probe_hash_table qpht_checker u_qpht_checker (.*);
